// ----- src/assert_macros.svh -----
// Assertion helpers used by ipv4_lpm_route_forwarder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/lpmfwd_pkg.sv -----
`timescale 1ns / 1ps
package lpmfwd_pkg;

	typedef enum logic [1:0] {
		CMD_ADD  = 2'd0,
		CMD_SEND = 2'd1,
		CMD_RECV = 2'd2,
		CMD_NONE = 2'd3
	} cmd_e;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_DUP     = 3'd1,
		ST_FULL    = 3'd2,
		ST_GW      = 3'd3,
		ST_DIRECT  = 3'd4,
		ST_NOROUTE = 3'd5,
		ST_EXPIRED = 3'd6
	} status_e;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned LEN_W  = 6;
	localparam int unsigned INTF_W = 4;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

	// Route attributes that a lookup or a duplicate check hands back.
	typedef struct packed {
		logic              direct;
		logic [ADDR_W-1:0] gateway;
		logic [INTF_W-1:0] intf;
	} route_t;

	typedef struct packed {
		logic [ADDR_W-1:0] prefix;
		logic [LEN_W-1:0]  length;
		route_t            route;
	} entry_t;

	typedef struct packed {
		logic   hit;
		route_t route;
	} hit_t;

	function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] m;
		if (len == '0) begin
			m = '0;
		end else if (len >= MAX_LEN) begin
			m = '1;
		end else begin
			m = ~(ADDR_W'({ADDR_W{1'b1}}) >> len);
		end
		return m;
	endfunction

endpackage

// ----- src/lpmfwd_req_if.sv -----
`timescale 1ns / 1ps
interface lpmfwd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] dest_address;
	logic [5:0]  prefix_len;
	logic        direct_route;
	logic [31:0] gateway_ip;
	logic [3:0]  out_intf;
	logic [7:0]  ttl_in;
	logic [15:0] payload_bytes;

	modport source (
		output valid, command, dest_address, prefix_len, direct_route,
		output gateway_ip, out_intf, ttl_in, payload_bytes,
		input  ready
	);
	modport sink (
		input  valid, command, dest_address, prefix_len, direct_route,
		input  gateway_ip, out_intf, ttl_in, payload_bytes,
		output ready
	);
endinterface

// ----- src/lpmfwd_rsp_if.sv -----
`timescale 1ns / 1ps
interface lpmfwd_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] hop_addr;
	logic [3:0]  hop_intf;
	logic        hop_intf_valid;
	logic [7:0]  ttl_out;
	logic [14:0] total_words;

	modport source (
		output valid, status, hop_addr, hop_intf, hop_intf_valid,
		output ttl_out, total_words,
		input  ready
	);
	modport sink (
		input  valid, status, hop_addr, hop_intf, hop_intf_valid,
		input  ttl_out, total_words,
		output ready
	);
endinterface

// ----- src/lpmfwd_table.sv -----
`timescale 1ns / 1ps
module lpmfwd_table #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  lpmfwd_pkg::entry_t  wdata,
	input  logic [AW-1:0]       raddr,
	output lpmfwd_pkg::entry_t  rdata
);

	lpmfwd_pkg::entry_t mem [DEPTH];
	lpmfwd_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/lpmfwd_match.sv -----
`timescale 1ns / 1ps
module lpmfwd_match #(
	parameter int unsigned AW = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clr,
	input  logic                                is_add,
	input  logic [lpmfwd_pkg::ADDR_W-1:0]       key,
	input  logic [lpmfwd_pkg::LEN_W-1:0]        add_len,
	input  logic                                ent_vld,
	input  logic [AW-1:0]                       ent_idx,
	input  lpmfwd_pkg::entry_t                  ent,
	output lpmfwd_pkg::hit_t                    lookup,
	output lpmfwd_pkg::hit_t                    same,
	output logic [AW-1:0]                       same_idx
);

	lpmfwd_pkg::hit_t                   best_q;
	lpmfwd_pkg::hit_t                   dflt_q;
	lpmfwd_pkg::hit_t                   same_q;
	logic [lpmfwd_pkg::LEN_W-1:0]       best_len_q;
	logic [AW-1:0]                      same_idx_q;
	logic [lpmfwd_pkg::ADDR_W-1:0]      mask;
	logic                               eq;

	// One comparator serves both uses: an add compares exact prefixes, a lookup
	// compares the destination under the entry's mask. A zero-length entry then
	// matches only when its prefix is zero, which is the default route.
	assign mask = is_add ? '1 : lpmfwd_pkg::len_mask(ent.length);
	assign eq   = ((key & mask) == ent.prefix);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '0;
			dflt_q     <= '0;
			same_q     <= '0;
			best_len_q <= '0;
			same_idx_q <= '0;
		end else if (clr) begin
			best_q.hit <= 1'b0;
			dflt_q.hit <= 1'b0;
			same_q.hit <= 1'b0;
			best_len_q <= '0;
		end else if (ent_vld) begin
			if (is_add) begin
				if (!same_q.hit && eq && ent.length == add_len) begin
					same_q.hit   <= 1'b1;
					same_q.route <= ent.route;
					same_idx_q   <= ent_idx;
				end
			end else if (eq && ent.length == '0) begin
				if (!dflt_q.hit) begin
					dflt_q.hit   <= 1'b1;
					dflt_q.route <= ent.route;
				end
			end else if (eq && ent.length > best_len_q) begin
				best_q.hit   <= 1'b1;
				best_q.route <= ent.route;
				best_len_q   <= ent.length;
			end
		end
	end

	assign lookup   = best_q.hit ? best_q : dflt_q;
	assign same     = same_q;
	assign same_idx = same_idx_q;

endmodule

// ----- src/ipv4_lpm_route_forwarder.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Contents
// req      in         command, address, route fields, TTL, payload size
// rsp      out        status, next hop, interface, TTL, length in words
//
// Each request is accepted in S_IDLE; S_SCAN then issues one read per installed
// route through the single table read port, and closes once the last read has
// left the table's read register; S_DONE then posts the result.
// arst_n clears the route count, so the table reads as empty after reset.
// The result waits in an output register; a stalled rsp holds the block in S_DONE,
// and req is accepted only between requests.
`include "assert_macros.svh"
module ipv4_lpm_route_forwarder #(
	parameter int unsigned TABLE_DEPTH  = 16,
	parameter int unsigned INTF_COUNT   = 16,
	parameter int unsigned HEADER_WORDS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	lpmfwd_req_if.sink          req,
	lpmfwd_rsp_if.source        rsp
);

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          addr_q;
	logic                   rvalid_s1;
	logic [AW-1:0]          ridx_s1;
	logic                   issue;
	logic                   accept;
	logic                   post;

	lpmfwd_pkg::cmd_e       cmd_q;
	logic [31:0]            dest_q;
	logic [31:0]            prefix_q;
	logic [5:0]             plen_q;
	lpmfwd_pkg::route_t     route_q;
	logic [7:0]             ttl_q;
	logic [15:0]            pay_q;

	logic [5:0]             plen_c;
	logic [3:0]             intf_c;

	lpmfwd_pkg::entry_t     rd_ent;
	lpmfwd_pkg::entry_t     wr_ent;
	lpmfwd_pkg::hit_t       lk;
	lpmfwd_pkg::hit_t       same;
	logic [AW-1:0]          same_idx;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;

	logic                   rsp_valid_q;
	lpmfwd_pkg::status_e    status_q;
	logic [31:0]            nh_q;
	logic [3:0]             hi_q;
	logic                   hv_q;
	logic [7:0]             tout_q;
	logic [14:0]            words_q;

	lpmfwd_pkg::status_e    status_d;
	logic [31:0]            nh_d;
	logic [3:0]             hi_d;
	logic                   hv_d;
	logic [7:0]             tout_d;
	logic [14:0]            words_d;
	logic                   grow;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign issue     = (state_q == S_SCAN) && (addr_q < count_q);
	assign post      = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	assign plen_c = (req.prefix_len > lpmfwd_pkg::MAX_LEN) ? lpmfwd_pkg::MAX_LEN
		: req.prefix_len;
	assign intf_c = (32'(req.out_intf) >= INTF_COUNT) ? 4'(INTF_COUNT - 1) : req.out_intf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			addr_q      <= '0;
			rvalid_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= issue;
			if (post) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					addr_q <= '0;
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						addr_q <= addr_q + 1'b1;
					end else if (!rvalid_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (post) begin
						if (grow) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= addr_q[AW-1:0];
		if (accept) begin
			cmd_q    <= lpmfwd_pkg::cmd_e'(req.command);
			dest_q   <= req.dest_address;
			prefix_q <= req.dest_address & lpmfwd_pkg::len_mask(plen_c);
			plen_q   <= plen_c;
			route_q.direct  <= req.direct_route;
			route_q.gateway <= req.direct_route ? '0 : req.gateway_ip;
			route_q.intf    <= req.direct_route ? '0 : intf_c;
			ttl_q    <= req.ttl_in;
			pay_q    <= req.payload_bytes;
		end
		if (post) begin
			status_q <= status_d;
			nh_q     <= nh_d;
			hi_q     <= hi_d;
			hv_q     <= hv_d;
			tout_q   <= tout_d;
			words_q  <= words_d;
		end
	end

	lpmfwd_table #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(wr_ent),
		.raddr(addr_q[AW-1:0]),
		.rdata(rd_ent)
	);

	lpmfwd_match #(
		.AW(AW)
	) u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (accept),
		.is_add  (cmd_q == lpmfwd_pkg::CMD_ADD),
		.key     ((cmd_q == lpmfwd_pkg::CMD_ADD) ? prefix_q : dest_q),
		.add_len (plen_q),
		.ent_vld (rvalid_s1),
		.ent_idx (ridx_s1),
		.ent     (rd_ent),
		.lookup  (lk),
		.same    (same),
		.same_idx(same_idx)
	);

	assign wr_ent.prefix = prefix_q;
	assign wr_ent.length = plen_q;
	assign wr_ent.route  = route_q;

	// Result and table update for the request at the end of its scan.
	always_comb begin
		status_d  = lpmfwd_pkg::ST_NOROUTE;
		nh_d      = '0;
		hi_d      = '0;
		hv_d      = 1'b0;
		tout_d    = '0;
		words_d   = '0;
		grow      = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = same.hit ? same_idx : count_q[AW-1:0];
		case (cmd_q)
			lpmfwd_pkg::CMD_ADD: begin
				if (same.hit && same.route == route_q) begin
					status_d = lpmfwd_pkg::ST_DUP;
				end else if (!same.hit && count_q == CW'(TABLE_DEPTH)) begin
					status_d = lpmfwd_pkg::ST_FULL;
				end else begin
					status_d = lpmfwd_pkg::ST_ADDED;
					mem_we   = post;
					grow     = !same.hit;
				end
			end
			lpmfwd_pkg::CMD_SEND: begin
				words_d = 15'(HEADER_WORDS) + 15'(pay_q[15:2]) + 15'(|pay_q[1:0]);
				if (lk.hit) begin
					if (lk.route.direct) begin
						status_d = lpmfwd_pkg::ST_DIRECT;
						nh_d     = dest_q;
					end else begin
						status_d = lpmfwd_pkg::ST_GW;
						nh_d     = lk.route.gateway;
						hi_d     = lk.route.intf;
						hv_d     = 1'b1;
					end
				end
			end
			lpmfwd_pkg::CMD_RECV: begin
				if (lk.hit) begin
					if (lk.route.direct) begin
						status_d = lpmfwd_pkg::ST_DIRECT;
						tout_d   = ttl_q;
					end else if (ttl_q <= 8'd1) begin
						status_d = lpmfwd_pkg::ST_EXPIRED;
					end else begin
						status_d = lpmfwd_pkg::ST_GW;
						nh_d     = lk.route.gateway;
						hi_d     = lk.route.intf;
						hv_d     = 1'b1;
						tout_d   = ttl_q - 8'd1;
					end
				end
			end
			default: begin
				status_d = lpmfwd_pkg::ST_NOROUTE;
			end
		endcase
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.hop_addr       = nh_q;
	assign rsp.hop_intf       = hi_q;
	assign rsp.hop_intf_valid = hv_q;
	assign rsp.ttl_out        = tout_q;
	assign rsp.total_words    = words_q;

	`ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(TABLE_DEPTH),
		"route count past table depth")
	`ASSERT_IMP(a_write_add, clk, arst_n, mem_we,
		(state_q == S_DONE) && (cmd_q == lpmfwd_pkg::CMD_ADD), "table written outside an add")
	`ASSERT_NXT(a_accept_scan, clk, arst_n, accept, state_q == S_SCAN,
		"accepted request did not start a scan")
	`ASSERT_IMP(a_scan_addr, clk, arst_n, state_q == S_SCAN, addr_q <= count_q,
		"scan address past the route count")

endmodule

// ----- bench/tb_ipv4_lpm_route_forwarder.sv -----
`timescale 1ns / 1ps
module tb_ipv4_lpm_route_forwarder;
	import lpmfwd_pkg::*;

	localparam int DEPTH           = 16;
	localparam int INTFS           = 16;
	localparam int HDR_WORDS       = 5;
	localparam int RANDOM_ITEMS    = 1900;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AFTER  = 700;
	localparam int DRAIN_CYCLES    = 60;
	// The slowest correct run is 1925 requests, each with its table scan, a sender gap
	// and a few receiver stalls, and stays well under the limit.
	localparam int CYCLE_LIMIT     = 1000000;

	typedef enum int {
		RX_OPEN,
		RX_RANDOM,
		RX_SPARSE,
		RX_PATTERN
	} rx_mode_e;

	typedef struct {
		cmd_e        command;
		logic [31:0] dest;
		logic [5:0]  plen;
		logic        direct;
		logic [31:0] gw;
		logic [3:0]  intf;
		logic [7:0]  ttl;
		logic [15:0] payload;
	} fwd_req_t;

	typedef struct {
		status_e     status;
		logic [31:0] next_hop;
		logic [3:0]  intf;
		logic        intf_valid;
		logic [7:0]  ttl;
		logic [14:0] words;
	} fwd_rsp_t;

	// Leading ones for a prefix length; lengths above 32 give a full mask.
	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		logic [31:0] m;
		m = '0;
		for (int b = 0; b < 32; b++) begin
			if (b < len) begin
				m[31-b] = 1'b1;
			end
		end
		return m;
	endfunction

	class route_scoreboard;
		bit          used [DEPTH];
		logic [31:0] prefix [DEPTH];
		logic [5:0]  length [DEPTH];
		bit          direct [DEPTH];
		logic [31:0] gateway [DEPTH];
		logic [3:0]  intf [DEPTH];
		fwd_rsp_t    pending [$];
		int          errors;
		int          results;

		function new();
			errors = 0;
			results = 0;
			for (int i = 0; i < DEPTH; i++) begin
				used[i] = 1'b0;
			end
		endfunction

		// Routes fill from the lowest slot and are never removed, so slots 0..n-1 are in use.
		function int route_count();
			int n;
			n = 0;
			for (int i = 0; i < DEPTH; i++) begin
				if (used[i]) begin
					n++;
				end
			end
			return n;
		endfunction

		function int find_route(logic [31:0] dest);
			int          best;
			int          dflt;
			logic [5:0]  best_len;
			best = -1;
			dflt = -1;
			best_len = '0;
			for (int i = 0; i < DEPTH; i++) begin
				if (used[i]) begin
					if (length[i] == 0 && prefix[i] == 0) begin
						if (dflt < 0) begin
							dflt = i;
						end
					end else if ((dest & prefix_mask(length[i])) == prefix[i] &&
							length[i] > best_len) begin
						best_len = length[i];
						best = i;
					end
				end
			end
			return (best >= 0) ? best : dflt;
		endfunction

		// Applies one request to the table copy and returns the response it must produce.
		function fwd_rsp_t forward(fwd_req_t r);
			fwd_rsp_t    e;
			logic [5:0]  plen;
			logic [31:0] pfx;
			logic [31:0] gw;
			logic [3:0]  itf;
			int          same;
			int          free_slot;
			int          slot;
			int          hit;
			e.status = ST_NOROUTE;
			e.next_hop = '0;
			e.intf = '0;
			e.intf_valid = 1'b0;
			e.ttl = '0;
			e.words = '0;
			case (r.command)
				CMD_ADD: begin
					plen = (r.plen > 6'd32) ? 6'd32 : r.plen;
					pfx = r.dest & prefix_mask(plen);
					gw = r.gw;
					itf = r.intf;
					if (itf >= INTFS) begin
						itf = 4'(INTFS - 1);
					end
					if (r.direct) begin
						gw = '0;
						itf = '0;
					end
					same = -1;
					free_slot = -1;
					for (int i = 0; i < DEPTH; i++) begin
						if (used[i]) begin
							if (same < 0 && prefix[i] == pfx && length[i] == plen) begin
								same = i;
							end
						end else if (free_slot < 0) begin
							free_slot = i;
						end
					end
					if (same >= 0 && direct[same] == r.direct && gateway[same] == gw &&
							intf[same] == itf) begin
						e.status = ST_DUP;
					end else begin
						slot = (same >= 0) ? same : free_slot;
						if (slot < 0) begin
							e.status = ST_FULL;
						end else begin
							used[slot] = 1'b1;
							prefix[slot] = pfx;
							length[slot] = plen;
							direct[slot] = r.direct;
							gateway[slot] = gw;
							intf[slot] = itf;
							e.status = ST_ADDED;
						end
					end
				end
				CMD_SEND: begin
					e.words = 15'(HDR_WORDS + (r.payload >> 2) + (r.payload[1:0] != 2'b00));
					hit = find_route(r.dest);
					if (hit >= 0) begin
						if (direct[hit]) begin
							e.status = ST_DIRECT;
							e.next_hop = r.dest;
						end else begin
							e.status = ST_GW;
							e.next_hop = gateway[hit];
							e.intf = intf[hit];
							e.intf_valid = 1'b1;
						end
					end
				end
				CMD_RECV: begin
					hit = find_route(r.dest);
					if (hit >= 0) begin
						if (direct[hit]) begin
							e.status = ST_DIRECT;
							e.ttl = r.ttl;
						end else if (r.ttl <= 8'd1) begin
							e.status = ST_EXPIRED;
						end else begin
							e.status = ST_GW;
							e.next_hop = gateway[hit];
							e.intf = intf[hit];
							e.intf_valid = 1'b1;
							e.ttl = r.ttl - 8'd1;
						end
					end
				end
				default: begin
				end
			endcase
			return e;
		endfunction

		function void note_request(fwd_req_t r);
			pending.push_back(forward(r));
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_result(fwd_rsp_t got);
			fwd_rsp_t want;
			results++;
			if (pending.size() == 0) begin
				report($sformatf("response %0d arrived with no request waiting", results));
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				report($sformatf("response %0d status %0d, predicted %0d",
					results, got.status, want.status));
			end
			if (got.next_hop !== want.next_hop) begin
				report($sformatf("response %0d next hop %h, predicted %h",
					results, got.next_hop, want.next_hop));
			end
			if (got.intf !== want.intf) begin
				report($sformatf("response %0d interface %0d, predicted %0d",
					results, got.intf, want.intf));
			end
			if (got.intf_valid !== want.intf_valid) begin
				report($sformatf("response %0d interface valid %b, predicted %b",
					results, got.intf_valid, want.intf_valid));
			end
			if (got.ttl !== want.ttl) begin
				report($sformatf("response %0d ttl %0d, predicted %0d",
					results, got.ttl, want.ttl));
			end
			if (got.words !== want.words) begin
				report($sformatf("response %0d total words %0d, predicted %0d",
					results, got.words, want.words));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	int   burst_left;

	route_scoreboard sb = new();

	lpmfwd_req_if req_ch();
	lpmfwd_rsp_if rsp_ch();

	ipv4_lpm_route_forwarder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		fwd_req_t rq;
		fwd_rsp_t rs;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				rq.command = cmd_e'(req_ch.command);
				rq.dest = req_ch.dest_address;
				rq.plen = req_ch.prefix_len;
				rq.direct = req_ch.direct_route;
				rq.gw = req_ch.gateway_ip;
				rq.intf = req_ch.out_intf;
				rq.ttl = req_ch.ttl_in;
				rq.payload = req_ch.payload_bytes;
				sb.note_request(rq);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				rs.status = status_e'(rsp_ch.status);
				rs.next_hop = rsp_ch.hop_addr;
				rs.intf = rsp_ch.hop_intf;
				rs.intf_valid = rsp_ch.hop_intf_valid;
				rs.ttl = rsp_ch.ttl_out;
				rs.words = rsp_ch.total_words;
				sb.check_result(rs);
			end
		end
	end

	// Receiver: switches between stall patterns at random, and once holds off long
	// enough for the block to back up into the request side.
	initial begin
		rx_mode_e mode;
		int       left;
		bit       held_once;
		rsp_ch.ready = 1'b0;
		mode = RX_OPEN;
		left = 0;
		held_once = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_once && sb.results >= HOLD_OFF_AFTER) begin
				held_once = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			if (left == 0) begin
				mode = rx_mode_e'($urandom_range(0, 3));
				left = $urandom_range(8, 120);
			end
			left--;
			case (mode)
				RX_OPEN:    rsp_ch.ready <= 1'b1;
				RX_RANDOM:  rsp_ch.ready <= ($urandom_range(0, 99) < 60);
				RX_SPARSE:  rsp_ch.ready <= ($urandom_range(0, 99) < 15);
				default:    rsp_ch.ready <= (left % 4 != 0);
			endcase
		end
	end

	function automatic fwd_req_t route_req(input cmd_e cmd, input logic [31:0] dest,
			input logic [5:0] plen, input logic direct, input logic [31:0] gw,
			input logic [3:0] intf, input logic [7:0] ttl, input logic [15:0] payload);
		fwd_req_t r;
		r.command = cmd;
		r.dest = dest;
		r.plen = plen;
		r.direct = direct;
		r.gw = gw;
		r.intf = intf;
		r.ttl = ttl;
		r.payload = payload;
		return r;
	endfunction

	// Valid stays high after acceptance; the caller either offers the next request or idles.
	task automatic push_request(input fwd_req_t r);
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.command <= r.command;
		req_ch.dest_address <= r.dest;
		req_ch.prefix_len <= r.plen;
		req_ch.direct_route <= r.direct;
		req_ch.gateway_ip <= r.gw;
		req_ch.out_intf <= r.intf;
		req_ch.ttl_in <= r.ttl;
		req_ch.payload_bytes <= r.payload;
		forever begin
			@(posedge clk);
			if (req_ch.ready) begin
				break;
			end
		end
	endtask

	task automatic idle_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
	endtask

	task automatic offer(input fwd_req_t r);
		push_request(r);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 3) != 0) begin
				idle_sender($urandom_range(1, 40));
			end
		end
	endtask

	initial begin
		fwd_req_t    r;
		logic [31:0] bases [4];
		int          pick;
		int          installed;
		int          k;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_NONE;
		req_ch.dest_address = '0;
		req_ch.prefix_len = '0;
		req_ch.direct_route = 1'b0;
		req_ch.gateway_ip = '0;
		req_ch.out_intf = '0;
		req_ch.ttl_in = '0;
		req_ch.payload_bytes = '0;
		burst_left = 0;
		for (int i = 0; i < 4; i++) begin
			bases[i] = $urandom();
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Empty table, then the unknown command with every field at its maximum.
		offer(route_req(CMD_SEND, 32'h0A010203, 6'd0, 1'b0, '0, '0, 8'd0, 16'd0));
		offer(route_req(CMD_RECV, 32'hC0A80001, 6'd0, 1'b0, '0, '0, 8'd64, 16'd0));
		offer(route_req(CMD_NONE, '1, 6'd63, 1'b1, '1, 4'd15, 8'd255, 16'hFFFF));
		// Default route from a nonzero address with length zero, then the same route again.
		offer(route_req(CMD_ADD, 32'h12345678, 6'd0, 1'b0, '1, 4'd15, 8'd0, 16'd0));
		offer(route_req(CMD_ADD, 32'h12345678, 6'd0, 1'b0, '1, 4'd15, 8'd0, 16'd0));
		// A length above 32 is clamped to a host route.
		offer(route_req(CMD_ADD, '1, 6'd63, 1'b1, 32'h01020304, 4'd7, 8'd0, 16'd0));
		offer(route_req(CMD_ADD, 32'h0A000000, 6'd8, 1'b0, 32'hC0A80101, 4'd0, 8'd0, 16'd0));
		// Direct routes drop their gateway and interface, so the second add is a duplicate.
		offer(route_req(CMD_ADD, 32'h0A01FFFF, 6'd16, 1'b1, 32'h00000055, 4'd9, 8'd0, 16'd0));
		offer(route_req(CMD_ADD, 32'h0A010000, 6'd16, 1'b1, 32'h000000AA, 4'd3, 8'd0, 16'd0));
		offer(route_req(CMD_ADD, 32'h0A000000, 6'd8, 1'b0, 32'hC0A80102, 4'd2, 8'd0, 16'd0));
		offer(route_req(CMD_SEND, 32'h0A010203, 6'd0, 1'b0, '0, '0, 8'd0, 16'hFFFF));
		offer(route_req(CMD_SEND, 32'h0A020304, 6'd0, 1'b0, '0, '0, 8'd0, 16'd1));
		offer(route_req(CMD_SEND, 32'h0B000000, 6'd0, 1'b0, '0, '0, 8'd0, 16'd4));
		offer(route_req(CMD_SEND, '1, 6'd0, 1'b0, '0, '0, 8'd0, 16'd3));
		offer(route_req(CMD_RECV, 32'h0A020304, 6'd0, 1'b0, '0, '0, 8'd0, 16'd0));
		offer(route_req(CMD_RECV, 32'h0A020304, 6'd0, 1'b0, '0, '0, 8'd1, 16'd0));
		offer(route_req(CMD_RECV, 32'h0A020304, 6'd0, 1'b0, '0, '0, 8'd2, 16'd0));
		offer(route_req(CMD_RECV, 32'h0A020304, 6'd0, 1'b0, '0, '0, 8'd255, 16'd0));
		offer(route_req(CMD_RECV, 32'h0A01ABCD, 6'd0, 1'b0, '0, '0, 8'd0, 16'd0));
		offer(route_req(CMD_RECV, '1, 6'd0, 1'b0, '0, '0, 8'd255, 16'd0));
		// A host route for address zero is not a default route and beats it.
		offer(route_req(CMD_ADD, 32'h00000000, 6'd32, 1'b0, 32'h00000000, 4'd0, 8'd0, 16'd0));
		offer(route_req(CMD_RECV, 32'h00000000, 6'd0, 1'b0, '0, '0, 8'd10, 16'd0));
		offer(route_req(CMD_ADD, 32'h00000000, 6'd0, 1'b1, '0, '0, 8'd0, 16'd0));
		offer(route_req(CMD_SEND, 32'h0B000000, 6'd0, 1'b0, '0, '0, 8'd0, 16'h8000));
		offer(route_req(CMD_NONE, '0, 6'd0, 1'b0, '0, '0, 8'd0, 16'd0));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			r.dest = $urandom();
			r.plen = 6'($urandom());
			r.direct = 1'($urandom());
			r.gw = $urandom();
			r.intf = 4'($urandom());
			r.ttl = 8'($urandom());
			r.payload = 16'($urandom());
			installed = sb.route_count();
			if (pick < 4) begin
				r.command = CMD_NONE;
			end else if (pick < 30) begin
				r.command = CMD_ADD;
				if (installed > 0 && $urandom_range(0, 1) == 1) begin
					// Revisit an installed prefix: the same route again or a replacement.
					k = $urandom_range(0, installed - 1);
					r.dest = sb.prefix[k] | ($urandom() & ~prefix_mask(sb.length[k]));
					r.plen = sb.length[k];
					if (sb.length[k] == 6'd32 && $urandom_range(0, 3) == 0) begin
						r.plen = 6'($urandom_range(33, 63));
					end
					if ($urandom_range(0, 1) == 1) begin
						r.direct = sb.direct[k];
						if (!sb.direct[k]) begin
							r.gw = sb.gateway[k];
							r.intf = sb.intf[k];
						end
					end
				end else begin
					// New prefixes cluster around a few bases so that routes nest.
					r.dest = bases[$urandom_range(0, 3)] ^ ($urandom() >> $urandom_range(4, 31));
					if ($urandom_range(0, 9) == 0) begin
						r.plen = 6'($urandom_range(33, 63));
					end else begin
						r.plen = 6'($urandom_range(0, 32));
					end
				end
			end else begin
				r.command = (pick < 65) ? CMD_SEND : CMD_RECV;
				if (installed > 0 && $urandom_range(0, 9) < 7) begin
					k = $urandom_range(0, installed - 1);
					r.dest = (sb.prefix[k] & prefix_mask(sb.length[k])) |
						($urandom() & ~prefix_mask(sb.length[k]));
				end
				if ($urandom_range(0, 4) == 0) begin
					r.ttl = 8'($urandom_range(0, 2));
				end
			end
			offer(r);
		end
		idle_sender(1);

		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
